[rtl/assert_macros.svh]
// Assertion macros used by the top level of the MAC learning table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, masked while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising clk edge, masked while rst is high.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
  `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

[rtl/mlt_pkg.sv]
// Types and constants of the MAC learning table.
package mlt_pkg;

  localparam int PORT_COUNT = 16;

  localparam logic [7:0] AGE_LIMIT_RESET = 8'd30;
  localparam logic [7:0] AGE_MAX         = 8'hFF;
  localparam logic [8:0] COUNT_MAX       = 9'h1FF;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_LEARN  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_UPDATED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [7:0]  age;
    logic [3:0]  port;
    logic [47:0] addr;
  } entry_t;

  typedef struct packed {
    logic   match;
    logic   free;
    logic   wr_en;
    logic   removed;
    entry_t wr_entry;
  } scan_info_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESULT
  } state_t;

endpackage

[rtl/mac_learning_table_with_aging.sv]
// Top level of the layer-2 MAC learning table with aging.
//
// Input items arrive on the s_* stream: s_tuser carries the operation (lookup,
// learn or aging tick) and s_tdata the MAC address and the port to learn.
// Every input transaction yields exactly one result transaction on m_*.
// The user must write the age limit on the cfg_* channel only while idle; unchecked.
//
// All entries sit in one table memory with a registered read. Every operation
// walks the whole table, one entry per cycle: lookups and learns search for
// the address and the lowest free slot, and a tick reads, ages and writes
// back each valid entry in flight. The next item is taken only once the
// result of the last one has moved into the output register.
//
// After reset a clearing pass writes every entry as free; s_tready stays low
// during the pass. A result waits in the output register while m_tready is
// low; the next item is still accepted and worked on, and its result is held
// until the register frees.
module mac_learning_table_with_aging import mlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: age_limit.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Input stream. tdata from bit 0: mac_address[47:0], port_in[3:0], zero pad.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  // tuser from bit 0: operation[1:0].
  input  logic [1:0]  s_tuser,
  // Result stream. tdata from bit 0: hit, port_out[3:0], status[1:0],
  // removed_count[8:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  // Table memory and its ports.
  entry_t           mem [TABLE_ENTRIES];
  entry_t           mem_rdata;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Scan counter, also the address counter of the clearing pass.
  logic [IDX_W-1:0] rd_idx;
  // Entry data that came out of the memory this cycle.
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_idx;

  // The item being worked on.
  logic [1:0]  item_op;
  logic [47:0] item_addr;
  logic [3:0]  item_port;

  // Search results gathered during the walk.
  logic             found;
  logic [IDX_W-1:0] found_idx;
  entry_t           found_entry;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [8:0]       removed_cnt;

  logic [7:0] age_limit;

  // Result waiting for the output register.
  logic [15:0] res;
  logic [15:0] res_next;

  scan_info_t info;
  logic       port_ok;

  mlt_entry_update u_entry_update (
    .op        (item_op),
    .addr      (item_addr),
    .age_limit (age_limit),
    .rd_entry  (mem_rdata),
    .info      (info)
  );

  assign cfg_ready = 1'b1;
  assign port_ok   = int'(item_port) < PORT_COUNT;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (rd_idx == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (rd_idx == LAST_IDX) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Outputs of the state machine: handshake, memory ports and the result.
  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pipe_idx;
    mem_wdata = info.wr_entry;
    res_next  = res;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_idx;
        mem_wdata = '0;
      end
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_SCAN, S_DRAIN: begin
        mem_re = (state == S_SCAN);
        // Aging writes back the entry whose data has just come out of the memory,
        // never the one being read now.
        mem_we = pipe_valid && info.wr_en;
      end
      S_FINISH: begin
        res_next        = '0;
        mem_wdata       = '0;
        mem_wdata.valid = 1'b1;
        if (item_op == OP_LOOKUP) begin
          if (found) begin
            // A hit refreshes the entry.
            mem_we         = 1'b1;
            mem_waddr      = found_idx;
            mem_wdata.port = found_entry.port;
            mem_wdata.addr = found_entry.addr;
            res_next[0]    = 1'b1;
            res_next[4:1]  = found_entry.port;
          end
        end else if (item_op == OP_LEARN) begin
          mem_wdata.port = item_port;
          mem_wdata.addr = item_addr;
          if (port_ok) begin
            if (found) begin
              mem_we        = 1'b1;
              mem_waddr     = found_idx;
              res_next[6:5] = ST_UPDATED;
            end else if (free_found) begin
              mem_we        = 1'b1;
              mem_waddr     = free_idx;
              res_next[6:5] = ST_ADDED;
            end else begin
              res_next[6:5] = ST_FULL;
            end
          end
        end else if (item_op == OP_TICK) begin
          res_next[15:7] = removed_cnt;
        end
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[rd_idx];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      rd_idx     <= '0;
      pipe_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      age_limit  <= AGE_LIMIT_RESET;
    end else begin
      state      <= state_next;
      pipe_valid <= mem_re;
      if (state == S_CLEAR || state == S_SCAN) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
      if (cfg_valid && cfg_ready) age_limit <= cfg_data;
      if (state == S_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and search registers.
  always_ff @(posedge clk) begin
    pipe_idx <= rd_idx;
    res      <= res_next;
    if (state == S_RESULT && (!m_tvalid || m_tready)) m_tdata <= res;
    if (s_tvalid && s_tready) begin
      item_op     <= s_tuser;
      item_addr   <= s_tdata[47:0];
      item_port   <= s_tdata[51:48];
      found       <= 1'b0;
      free_found  <= 1'b0;
      removed_cnt <= '0;
    end else if (pipe_valid) begin
      // Keep the first match and the lowest free slot.
      if (info.match && !found) begin
        found       <= 1'b1;
        found_idx   <= pipe_idx;
        found_entry <= mem_rdata;
      end
      if (info.free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pipe_idx;
      end
      if (info.removed && removed_cnt != COUNT_MAX) removed_cnt <= removed_cnt + 9'd1;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_no_rw_collision, mem_we && mem_re, mem_waddr != rd_idx,
    "table write and read hit the same entry")
  `ASSERT_CLK(a_one_item_at_a_time, (s_tvalid && s_tready) |=> !s_tready,
    "a second item was accepted while one is at work")
  `ASSERT_IMPLIES(a_result_fields_exclusive, m_tvalid && m_tdata[6:5] != ST_OK,
    !m_tdata[0] && m_tdata[15:7] == 9'd0, "learn status mixed with lookup or tick fields")
  `ASSERT_IMPLIES(a_removed_bounded, m_tvalid, int'(m_tdata[15:7]) <= TABLE_ENTRIES,
    "removed count exceeds the table size")

endmodule

[rtl/mlt_entry_update.sv]
// Per-entry evaluation: address match, free slot and aging write-back.
module mlt_entry_update import mlt_pkg::*; (
  input  logic [1:0]  op,
  input  logic [47:0] addr,
  input  logic [7:0]  age_limit,
  input  entry_t      rd_entry,
  output scan_info_t  info
);

  logic [7:0] age_inc;
  logic       expire;

  always_comb begin
    age_inc = (rd_entry.age == AGE_MAX) ? rd_entry.age : rd_entry.age + 8'd1;
    expire  = (age_inc >= age_limit);

    info.match          = rd_entry.valid && (rd_entry.addr == addr);
    info.free           = !rd_entry.valid;
    info.wr_en          = (op == OP_TICK) && rd_entry.valid;
    info.removed        = (op == OP_TICK) && rd_entry.valid && expire;
    info.wr_entry       = rd_entry;
    info.wr_entry.age   = age_inc;
    info.wr_entry.valid = !expire;
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the MAC learning table with aging.
module testbench import mlt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The table size used for this run; the predictor mirrors it.
  localparam int TABLE_DEPTH = 256;

  // Operation code 3 is not used by the block and must leave everything alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles to let pass after the last result before the age limit is changed.
  localparam int SETTLE_CYCLES = 4;

  // The end wait covers the walk of one more item through the table.
  localparam int TAIL_CYCLES = TABLE_DEPTH + 10;

  // Length of the one long output stall that fills the block and blocks its input.
  localparam int HOLD_CYCLES = 2000;

  // A correct run never goes this long without any transaction on any channel.
  // The slowest gap is an item plus the long stall plus a sender gap.
  localparam int WATCHDOG_LIMIT = 20000;

  localparam int MAX_REPORTS = 10;
  localparam int POOL_SIZE   = 16;
  localparam int RANDOM_ITEMS_PER_PHASE = 50;

  // One result transaction, laid out like m_tdata with hit in bit 0.
  typedef struct packed {
    logic [8:0] removed;
    logic [1:0] status;
    logic [3:0] port;
    logic       hit;
  } fdb_result_t;

  // One row of the directed stimulus. When write_limit is set, the age limit is
  // written before the item is sent. When typed is set, res is the expected
  // result; otherwise the predictor supplies it.
  typedef struct packed {
    bit          write_limit;
    logic [7:0]  limit;
    logic [1:0]  op;
    logic [47:0] mac;
    logic [3:0]  port;
    bit          typed;
    fdb_result_t res;
  } dir_row_t;

  localparam logic [47:0] MAC_ZERO = 48'h0000_0000_0000;
  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

  localparam fdb_result_t RES_NONE  = '0;
  localparam fdb_result_t RES_ADDED =
    '{removed: 9'd0, status: ST_ADDED, port: 4'd0, hit: 1'b0};
  localparam fdb_result_t RES_UPDATED =
    '{removed: 9'd0, status: ST_UPDATED, port: 4'd0, hit: 1'b0};
  localparam fdb_result_t RES_HIT_P0 =
    '{removed: 9'd0, status: ST_OK, port: 4'd0, hit: 1'b1};
  localparam fdb_result_t RES_HIT_P15 =
    '{removed: 9'd0, status: ST_OK, port: 4'd15, hit: 1'b1};
  localparam fdb_result_t RES_HIT_P5 =
    '{removed: 9'd0, status: ST_OK, port: 4'd5, hit: 1'b1};

  // The directed part. It starts from the reset age limit, covers both address
  // extremes, every operation, an update of a known address, the unused code,
  // and the age limit at one, at zero and at its maximum.
  localparam dir_row_t DIRECTED [0:21] = '{
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ZERO,          4'd0,  1'b1, RES_NONE},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ONES,          4'd15, 1'b1, RES_NONE},
    '{1'b0, 8'd0,   OP_LEARN,  MAC_ZERO,          4'd0,  1'b1, RES_ADDED},
    '{1'b0, 8'd0,   OP_LEARN,  MAC_ONES,          4'd15, 1'b1, RES_ADDED},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ZERO,          4'd0,  1'b1, RES_HIT_P0},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ONES,          4'd0,  1'b1, RES_HIT_P15},
    '{1'b0, 8'd0,   OP_LEARN,  MAC_ONES,          4'd5,  1'b1, RES_UPDATED},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ONES,          4'd0,  1'b1, RES_HIT_P5},
    '{1'b0, 8'd0,   OP_UNUSED, MAC_ONES,          4'd15, 1'b1, RES_NONE},
    '{1'b0, 8'd0,   OP_LEARN,  48'h0123_4567_89AB, 4'd10, 1'b1, RES_ADDED},
    '{1'b0, 8'd0,   OP_TICK,   48'hAAAA_AAAA_AAAA, 4'd10, 1'b1, RES_NONE},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ZERO,          4'd0,  1'b1, RES_HIT_P0},
    '{1'b1, 8'd2,   OP_TICK,   MAC_ZERO,          4'd0,  1'b0, RES_NONE},
    '{1'b0, 8'd0,   OP_LOOKUP, MAC_ONES,          4'd0,  1'b0, RES_NONE},
    '{1'b1, 8'd1,   OP_LEARN,  48'h5555_5555_5555, 4'd6,  1'b0, RES_NONE},
    '{1'b0, 8'd0,   OP_TICK,   MAC_ONES,          4'd15, 1'b0, RES_NONE},
    '{1'b1, 8'd0,   OP_LEARN,  48'h8000_0000_0001, 4'd9,  1'b0, RES_NONE},
    '{1'b0, 8'd0,   OP_TICK,   MAC_ZERO,          4'd0,  1'b0, RES_NONE},
    '{1'b1, 8'd255, OP_LEARN,  48'h0000_0000_0001, 4'd1,  1'b0, RES_NONE},
    '{1'b0, 8'd0,   OP_TICK,   MAC_ZERO,          4'd0,  1'b0, RES_NONE},
    '{1'b0, 8'd0,   OP_LOOKUP, 48'h0000_0000_0001, 4'd0,  1'b0, RES_NONE},
    '{1'b1, AGE_LIMIT_RESET, OP_TICK, MAC_ZERO,  4'd0,  1'b0, RES_NONE}
  };

  // Every input starts at a known value; the initializers are not NBAs.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = OP_LOOKUP;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;

  // The predictor's own copy of the forwarding table and its age limit.
  bit          fdb_valid [TABLE_DEPTH];
  logic [47:0] fdb_addr  [TABLE_DEPTH];
  logic [3:0]  fdb_port  [TABLE_DEPTH];
  logic [7:0]  fdb_age   [TABLE_DEPTH];
  logic [7:0]  age_limit_q = AGE_LIMIT_RESET;
  int          entries_used = 0;

  // Results still owed by the block, oldest first.
  fdb_result_t expected_q [$];

  // Idling controls, in percent of cycles for both the sender and the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;

  // Run statistics for the closing summary.
  int mismatches    = 0;
  int items_sent    = 0;
  int lookups       = 0;
  int lookup_hits   = 0;
  int learns_added  = 0;
  int learns_update = 0;
  int learns_full   = 0;
  int ticks         = 0;
  int freed_total   = 0;
  int max_freed     = 0;
  int limit_writes  = 0;

  logic [47:0] mac_pool [POOL_SIZE];

  mac_learning_table_with_aging #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // From bit 0: mac_address[47:0], port_in[3:0], zero pad.
    .s_tuser  (s_tuser),   // From bit 0: operation[1:0].
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // From bit 0: hit, port_out[3:0], status[1:0], removed_count[8:0].
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Returns a random 48-bit address.
  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Slot that holds a valid copy of mac, or -1 when the address is unknown.
  function automatic int fdb_find(input logic [47:0] mac);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (fdb_valid[k] && fdb_addr[k] == mac) return k;
    end
    return -1;
  endfunction

  // Applies one item to the predictor's table and returns the result it owes.
  function automatic fdb_result_t fdb_predict(input logic [1:0] op,
                                              input logic [47:0] mac,
                                              input logic [3:0] prt);
    fdb_result_t r;
    int slot;
    r = '0;
    slot = -1;
    case (op)
      OP_LOOKUP: begin
        slot = fdb_find(mac);
        if (slot >= 0) begin
          r.hit = 1'b1;
          r.port = fdb_port[slot];
          fdb_age[slot] = 8'd0;
        end
      end
      OP_LEARN: begin
        if (int'(prt) < PORT_COUNT) begin
          slot = fdb_find(mac);
          if (slot >= 0) begin
            // A known address moves to the new port and becomes young again.
            fdb_port[slot] = prt;
            fdb_age[slot] = 8'd0;
            r.status = ST_UPDATED;
          end else begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
              if (!fdb_valid[k] && slot < 0) slot = k;
            end
            if (slot >= 0) begin
              fdb_valid[slot] = 1'b1;
              fdb_addr[slot] = mac;
              fdb_port[slot] = prt;
              fdb_age[slot] = 8'd0;
              entries_used++;
              r.status = ST_ADDED;
            end else begin
              r.status = ST_FULL;
            end
          end
        end
      end
      OP_TICK: begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (fdb_valid[k]) begin
            if (fdb_age[k] != AGE_MAX) fdb_age[k] = fdb_age[k] + 8'd1;
            if (fdb_age[k] >= age_limit_q) begin
              fdb_valid[k] = 1'b0;
              entries_used--;
              if (r.removed != COUNT_MAX) r.removed = r.removed + 9'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Offers one item, waits for its transaction, and records what it must yield.
  // Before the offer the sender idles cycle by cycle at send_idle_pct percent.
  // s_tvalid is left high on return; the next call either reuses it or lowers
  // it once per idle cycle, so it never gets two assignments in one step.
  task automatic send_item(input logic [1:0] op, input logic [47:0] mac,
                           input logic [3:0] prt, input bit typed,
                           input fdb_result_t typed_res);
    fdb_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, prt, mac};
    do @(posedge clk); while (!s_tready);
    pred = fdb_predict(op, mac, prt);
    expected_q.push_back(typed ? typed_res : pred);
    items_sent++;
    case (op)
      OP_LOOKUP: begin
        lookups++;
        if (pred.hit) lookup_hits++;
      end
      OP_LEARN: begin
        if (pred.status == ST_ADDED) learns_added++;
        if (pred.status == ST_UPDATED) learns_update++;
        if (pred.status == ST_FULL) learns_full++;
      end
      OP_TICK: begin
        ticks++;
        freed_total += int'(pred.removed);
        if (int'(pred.removed) > max_freed) max_freed = int'(pred.removed);
      end
      default: begin
      end
    endcase
  endtask

  // Stops offering items and waits until every owed result has arrived.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the age limit while the block has nothing in flight.
  task automatic write_age_limit(input logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    age_limit_q = value;
    limit_writes++;
  endtask

  // Receiver: random back-pressure, or one long stall on request. The stall is
  // counted here so that the sender keeps offering items while it lasts.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every result transaction is checked against the oldest owed result. Signals
  // are sampled at the edge, before any nonblocking update of that edge lands.
  always @(posedge clk) begin
    fdb_result_t got;
    fdb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = fdb_result_t'(m_tdata);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result hit=%0d port=%0d status=%0d removed=%0d",
                   $realtime, got.hit, got.port, got.status, got.removed);
        end
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit || got.port !== want.port ||
            got.status !== want.status || got.removed !== want.removed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result mismatch: expected hit=%0d port=%0d status=%0d removed=%0d",
                     $realtime, want.hit, want.port, want.status, want.removed);
            $display("%0t:                  actual   hit=%0d port=%0d status=%0d removed=%0d",
                     $realtime, got.hit, got.port, got.status, got.removed);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles with no transaction on any channel. The clearing
  // pass after reset and the long output stall both stay well below the limit.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, expected_q.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed rows, a fill to a full table, then three
  // random phases with different idling patterns and age limits.
  initial begin
    int kind;
    int pick;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The first idling pattern: the sender idles in a quarter of the cycles and
    // the receiver in about half of them.
    send_idle_pct = 25;
    recv_idle_pct = 51;

    // The directed rows begin with the age limit still at its reset value.
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].write_limit) write_age_limit(DIRECTED[i].limit);
      send_item(DIRECTED[i].op, DIRECTED[i].mac, DIRECTED[i].port,
                DIRECTED[i].typed, DIRECTED[i].res);
    end

    // Fill every slot with learned addresses, then show that new addresses are
    // dropped while a known one still updates.
    while (entries_used < TABLE_DEPTH) begin
      send_item(OP_LEARN, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
    end
    repeat (4) send_item(OP_LEARN, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
    send_item(OP_LEARN, fdb_addr[TABLE_DEPTH - 1], 4'd15, 1'b1, RES_UPDATED);
    send_item(OP_LOOKUP, fdb_addr[0], 4'd0, 1'b0, RES_NONE);

    // With a limit of one, the next tick frees the whole table at once.
    write_age_limit(8'd1);
    send_item(OP_TICK, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);

    // Random items over a small pool of addresses, so that lookups hit, learns
    // update, and ticks age out entries that were not refreshed.
    for (int k = 0; k < POOL_SIZE; k++) mac_pool[k] = rand_mac();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: write_age_limit(8'd3);
        1: write_age_limit(8'd255);
        default: write_age_limit(8'($urandom_range(1, 12)));
      endcase
      if (phase == 1) begin
        // The other idling pattern, and one long output stall that backs the
        // block up into its input while the sender keeps offering items.
        send_idle_pct = 51;
        recv_idle_pct = 25;
        hold_request = 1'b1;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, POOL_SIZE - 1);
        if (kind < 35) begin
          send_item(OP_LEARN, mac_pool[pick], 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
        end else if (kind < 70) begin
          send_item(OP_LOOKUP, mac_pool[pick], 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
        end else if (kind < 82) begin
          send_item(OP_TICK, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
        end else if (kind < 87) begin
          send_item(OP_UNUSED, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
        end else begin
          // Lookups of addresses that were most likely never learned.
          send_item(OP_LOOKUP, rand_mac(), 4'($urandom_range(0, 15)), 1'b0, RES_NONE);
        end
      end
      // The sender pauses here until every owed result has come back.
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d lookups with %0d hits, %0d adds, %0d updates, %0d drops",
             items_sent, lookups, lookup_hits, learns_added, learns_update, learns_full);
    $display("covered %0d ticks freeing %0d entries (at most %0d at once), %0d limit writes",
             ticks, freed_total, max_freed, limit_writes);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
